>>> rtl/additive_lagged_fibonacci_rng_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the additive lagged-Fibonacci generator core
// Shared wrappers tying concurrent assertions to the core clock, one also to reset.
// ----------------------------------------------------------------------------
`ifndef ADDITIVE_LAGGED_FIBONACCI_RNG_CORE_MACROS_SVH
`define ADDITIVE_LAGGED_FIBONACCI_RNG_CORE_MACROS_SVH

// Checked only outside reset.
`define ALF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define ALF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/alf_rng_pkg.sv
// ----------------------------------------------------------------------------
// Additive lagged-Fibonacci generator package
// Word widths, recurrence constants, request codes and parameter defaults.
// ----------------------------------------------------------------------------
package alf_rng_pkg;

  // Field and table word widths.
  localparam int unsigned WORD_W = 64;
  localparam int unsigned SEED_W = 32;
  localparam int unsigned RAND_W = 32;
  localparam int unsigned MUL_W  = 32;
  localparam int unsigned MULT_W = 31;

  // Default table geometry of the x^31 + x^3 + 1 trinomial.
  localparam int unsigned DEF_TABLE_DEPTH    = 31;
  localparam int unsigned DEF_LAG_SEPARATION = 3;

  // Linear congruential seeding recurrence.
  localparam logic [MULT_W-1:0] LCG_MULT = 31'd1103515145;
  localparam logic [WORD_W-1:0] LCG_INC  = 64'd12345;

  // Number of full passes over the table run silently after a reseed.
  localparam int unsigned WARMUP_ROUNDS = 10;

  // Request operation codes.
  localparam logic OP_SEED = 1'b0;
  localparam logic OP_NEXT = 1'b1;

endpackage

>>> rtl/additive_lagged_fibonacci_rng_core.sv
// ----------------------------------------------------------------------------
// Additive lagged-Fibonacci random number generator core
// 64-bit word table; a sequencer uses one 32x31 multiplier for seeding and
// shares one 64-bit adder between seeding, warm-up and word generation.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                  Payload
//  -------  ---------  -------------------------  --------------------------
//  in       sink       in_valid_i / in_stall_o    op_i, seed_value_i
//  out      source     out_valid_o / out_stall_i  random_word_o
//
//  A next request steps through accept, a registered table read, and add and
//  write back.
//  A seed request writes the seed into entry 0, then fills each further entry
//  by a split multiply (low half, high half, add and write), then runs
//  WARMUP_ROUNDS passes of warm-up steps, each a table read, add and write back.
//  After reset the table reads as zero until it is written; no clearing pass.
//  A finished word waits in the output register; a next request that finds
//  it still stalled holds in its write-back cycle until it is taken.

`include "additive_lagged_fibonacci_rng_core_macros.svh"

module additive_lagged_fibonacci_rng_core #(
  parameter int unsigned TABLE_DEPTH    = alf_rng_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned LAG_SEPARATION = alf_rng_pkg::DEF_LAG_SEPARATION
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            op_i,
  input  logic [alf_rng_pkg::SEED_W-1:0]  seed_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [alf_rng_pkg::RAND_W-1:0]  random_word_o
);

  localparam int unsigned IdxW      = $clog2(TABLE_DEPTH);
  localparam int unsigned LagMod    = LAG_SEPARATION % TABLE_DEPTH;
  localparam int unsigned WarmSteps = alf_rng_pkg::WARMUP_ROUNDS * TABLE_DEPTH;
  localparam int unsigned CntW      = $clog2(WarmSteps);
  localparam int unsigned ProdW     = alf_rng_pkg::MUL_W + alf_rng_pkg::MULT_W;
  localparam int unsigned WordW     = alf_rng_pkg::WORD_W;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_MUL_LO  = 6'b000010,
    ST_MUL_HI  = 6'b000100,
    ST_FILL_WR = 6'b001000,
    ST_STEP_RD = 6'b010000,
    ST_STEP_WR = 6'b100000
  } state_e;

  // Cyclic index advance with wrap at the table end.
  function automatic logic [IdxW-1:0] bump_idx(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] nxt;
    nxt = idx + 1'b1;
    if (idx == IdxW'(TABLE_DEPTH - 1)) begin
      nxt = '0;
    end
    return nxt;
  endfunction

  state_e              state_q, state_d;
  logic [IdxW-1:0]     front_q, front_d;
  logic [IdxW-1:0]     rear_q, rear_d;
  logic [IdxW-1:0]     fill_idx_q, fill_idx_d;
  logic [CntW-1:0]     warm_cnt_q, warm_cnt_d;
  logic                warm_q, warm_d;
  logic                out_valid_q, out_valid_d;
  logic [alf_rng_pkg::RAND_W-1:0] out_word_q, out_word_d;
  logic [WordW-1:0]    cur_q, cur_d;
  logic [WordW-1:0]    acc_q, acc_d;
  logic [ProdW-1:0]    mul_q, mul_d;
  logic [TABLE_DEPTH-1:0] entry_vld_q, entry_vld_d;

  logic [WordW-1:0]    word_mem [TABLE_DEPTH];
  logic [WordW-1:0]    rd_front_q, rd_rear_q;

  logic                in_accept;
  logic                out_take;
  logic                wr_en;
  logic [IdxW-1:0]     wr_addr;
  logic [WordW-1:0]    wr_data;
  logic [alf_rng_pkg::MUL_W-1:0] mul_a;
  logic [WordW-1:0]    add_a, add_b, add_sum;
  logic [IdxW:0]       lag_sum, lag_pos;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_take  = out_valid_q && !out_stall_i;

  // Shared multiplier: low or high half of the current seed word.
  assign mul_a = (state_q == ST_MUL_HI) ? cur_q[WordW-1:alf_rng_pkg::MUL_W]
                                        : cur_q[alf_rng_pkg::MUL_W-1:0];

  // Shared adder operand selection.
  always_comb begin
    unique case (state_q)
      ST_MUL_HI: begin
        add_a = WordW'(mul_q);
        add_b = alf_rng_pkg::LCG_INC;
      end
      ST_FILL_WR: begin
        add_a = acc_q;
        add_b = {mul_q[alf_rng_pkg::MUL_W-1:0], {alf_rng_pkg::MUL_W{1'b0}}};
      end
      default: begin
        add_a = rd_front_q;
        add_b = rd_rear_q;
      end
    endcase
  end

  assign add_sum = add_a + add_b;

  // Sequencer and datapath register update.
  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    rear_d      = rear_q;
    fill_idx_d  = fill_idx_q;
    warm_cnt_d  = warm_cnt_q;
    warm_d      = warm_q;
    out_valid_d = out_valid_q && !out_take;
    out_word_d  = out_word_q;
    cur_d       = cur_q;
    acc_d       = acc_q;
    mul_d       = mul_q;
    entry_vld_d = entry_vld_q;
    wr_en       = 1'b0;
    wr_addr     = front_q;
    wr_data     = add_sum;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (op_i == alf_rng_pkg::OP_SEED) begin
            wr_en       = 1'b1;
            wr_addr     = '0;
            wr_data     = WordW'(seed_value_i);
            entry_vld_d[0] = 1'b1;
            cur_d       = WordW'(seed_value_i);
            fill_idx_d  = IdxW'(1);
            front_d     = IdxW'(LagMod);
            rear_d      = '0;
            warm_d      = 1'b1;
            state_d     = ST_MUL_LO;
          end else begin
            warm_d  = 1'b0;
            state_d = ST_STEP_RD;
          end
        end
      end
      ST_MUL_LO: begin
        mul_d   = ProdW'(mul_a * alf_rng_pkg::LCG_MULT);
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        acc_d   = add_sum;
        mul_d   = ProdW'(mul_a * alf_rng_pkg::LCG_MULT);
        state_d = ST_FILL_WR;
      end
      ST_FILL_WR: begin
        wr_en   = 1'b1;
        wr_addr = fill_idx_q;
        entry_vld_d[fill_idx_q] = 1'b1;
        cur_d   = add_sum;
        if (fill_idx_q == IdxW'(TABLE_DEPTH - 1)) begin
          warm_cnt_d = '0;
          state_d    = ST_STEP_RD;
        end else begin
          fill_idx_d = fill_idx_q + 1'b1;
          state_d    = ST_MUL_LO;
        end
      end
      ST_STEP_RD: begin
        state_d = ST_STEP_WR;
      end
      ST_STEP_WR: begin
        // A next request waits here while the previous word is held and stalled.
        if (warm_q || !out_valid_q || !out_stall_i) begin
          wr_en   = 1'b1;
          wr_addr = front_q;
          entry_vld_d[front_q] = 1'b1;
          front_d = bump_idx(front_q);
          rear_d  = bump_idx(rear_q);
          if (warm_q) begin
            warm_cnt_d = warm_cnt_q + 1'b1;
            if (warm_cnt_q == CntW'(WarmSteps - 1)) begin
              state_d = ST_IDLE;
            end else begin
              state_d = ST_STEP_RD;
            end
          end else begin
            out_valid_d = 1'b1;
            out_word_d  = add_sum[alf_rng_pkg::RAND_W:1];
            state_d     = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= IdxW'(LagMod);
      rear_q      <= '0;
      fill_idx_q  <= '0;
      warm_cnt_q  <= '0;
      warm_q      <= 1'b0;
      out_valid_q <= 1'b0;
      entry_vld_q <= '0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      rear_q      <= rear_d;
      fill_idx_q  <= fill_idx_d;
      warm_cnt_q  <= warm_cnt_d;
      warm_q      <= warm_d;
      out_valid_q <= out_valid_d;
      entry_vld_q <= entry_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
    cur_q      <= cur_d;
    acc_q      <= acc_d;
    mul_q      <= mul_d;
  end

  // Word table: one write port, two registered read ports. Entries not yet
  // written since reset read as zero.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      word_mem[wr_addr] <= wr_data;
    end
    rd_front_q <= entry_vld_q[front_q] ? word_mem[front_q] : '0;
    rd_rear_q  <= entry_vld_q[rear_q] ? word_mem[rear_q] : '0;
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign random_word_o = out_word_q;

  // Expected front position derived from the rear index.
  assign lag_sum = {1'b0, rear_q} + (IdxW + 1)'(LagMod);
  assign lag_pos = (lag_sum >= (IdxW + 1)'(TABLE_DEPTH)) ?
                   lag_sum - (IdxW + 1)'(TABLE_DEPTH) : lag_sum;

  // Assertions.
  `ALF_ASSERT(a_idx_range, (front_q < IdxW'(TABLE_DEPTH)) && (rear_q < IdxW'(TABLE_DEPTH)), "Table index out of range")
  `ALF_ASSERT(a_lag_kept, lag_pos[IdxW-1:0] == front_q, "Rear index lost its lag behind front")
  `ALF_ASSERT(a_result_src, $rose(out_valid_o) |-> $past(state_q == ST_STEP_WR) && !$past(warm_q), "Result raised outside a next request")
  `ALF_ASSERT(a_seed_silent, (in_accept && op_i == alf_rng_pkg::OP_SEED) |=> warm_q, "Seed request not marked silent")

endmodule
